[rtl/fbd_pkg.sv]
// Fractional baud divider search: shared types and constants.
// Used by fbd_div and fractional_baud_divider_search. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

  // Shared divider operand widths
  localparam int DW    = 27;            // dividend / quotient
  localparam int VW    = 23;            // divisor / remainder
  localparam int CNT_W = $clog2(DW);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CfgMainClk = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CfgUartDiv = 2'd1;

  localparam logic [26:0] MainClkRst = 27'd12000000;
  localparam logic [7:0]  UartDivRst = 8'd1;

  localparam logic [16:0] NoErr      = 17'd100000;
  localparam logic [6:0]  PctScale   = 7'd100;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] num;
    logic [VW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] quo;
    logic [VW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/fbd_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fbd_pkg for widths and request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module fbd_div (
  input  wire              clk,
  input  wire              rst_n,
  input  fbd_pkg::div_req_t req,
  output fbd_pkg::div_rsp_t rsp
);
  import fbd_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    num_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    den_r;
  logic [VW:0]      shifted;
  logic [VW+1:0]    diff;

  assign shifted = {rem_r, num_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        // quotient bits shift in where dividend bits leave
        num_r <= {num_r[DW-2:0], ~diff[VW+1]};
        rem_r <= diff[VW+1] ? shifted[VW-1:0] : diff[VW-1:0];
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = num_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

[rtl/fractional_baud_divider_search.sv]
// Fractional baud divider search, top level: search sequencer and config registers.
// Depends on fbd_pkg and fbd_div (one shared iterative divider).
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+-----------------
//   in      | in_baud_rate                                 | in_valid/in_ready
//   out     | out_divisor out_mul_val out_div_add_val      | out_valid/out_ready
//           | out_best_error out_accepted                  |
//   cfg     | cfg_index cfg_data                           | cfg_we (no wait)
//
// One word at a time. Every division runs on the single divider.
// Per pair: scale, quotient and rate divisions; a skipped pair runs only scale and quotient.
// A full search covers 15x16 pairs; a zero-error hit ends it early.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready
// does not block the next word, but the next result waits for the slot.
// Reset is synchronous; config registers reset to 12 MHz and divider 1.
`timescale 1ns / 1ps
`default_nettype none

module fractional_baud_divider_search #(
  parameter int MAX_FRACTION = 15
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [22:0]                       in_baud_rate,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [15:0]                       out_divisor,
  output logic [3:0]                        out_mul_val,
  output logic [3:0]                        out_div_add_val,
  output logic [16:0]                       out_best_error,
  output logic                              out_accepted,
  input  wire                               cfg_we,
  input  wire  [fbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [26:0]                       cfg_data
);
  import fbd_pkg::*;

  localparam logic [3:0] MaxFr = 4'(MAX_FRACTION);

  typedef enum logic [2:0] {
    S_IDLE, S_UCLK, S_PAIR, S_SCALE, S_QUOT, S_RATE, S_ACC, S_OUT
  } state_t;

  state_t      state_r;
  logic [26:0] main_clk_r;
  logic [7:0]  uart_div_r;
  logic [22:0] baud_r;
  logic [22:0] uclk_r;
  logic [DW-1:0] scaled_r;
  logic [15:0] cand_div_r;
  logic [3:0]  mul_r, add_r;
  logic        lez_r;          // last computed error was zero
  logic [15:0] best_div_r;
  logic [3:0]  best_mul_r, best_add_r;
  logic [16:0] best_err_r;
  logic        out_valid_r;
  logic [15:0] out_div_r;
  logic [3:0]  out_mul_r, out_add_r;
  logic [16:0] out_err_r;
  logic        out_acc_r;
  logic [DW-1:0] thresh_r;
  logic        div_go_r;
  logic [DW-1:0] div_num_r;
  logic [VW-1:0] div_den_r;

  div_req_t req;
  div_rsp_t rsp;

  fbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign req.go  = div_go_r;
  assign req.num = div_num_r;
  assign req.den = div_den_r;

  // datapath helpers
  logic [7:0]    clkdiv_eff;
  logic          round_up;
  logic [DW:0]   dq;
  logic          dq_ok;
  logic [DW-1:0] err;
  logic          err_zero;
  logic          better;
  logic          step_lez;
  logic          adv_finish;
  logic [DW-1:0] scale_num;
  logic [4:0]    scale_den;
  logic [DW-1:0] baud_x3;

  assign clkdiv_eff = (uart_div_r == 8'd0) ? 8'd1 : uart_div_r;
  assign round_up   = rsp.rem > (baud_r >> 1);
  assign dq         = {1'b0, rsp.quo} + {{DW{1'b0}}, round_up};
  assign dq_ok      = (dq[DW:16] == '0) && (dq[15:0] != 16'd0);
  assign err        = (rsp.quo >= {4'd0, baud_r}) ? (rsp.quo - {4'd0, baud_r})
                                                  : ({4'd0, baud_r} - rsp.quo);
  assign err_zero   = (err == '0);
  assign better     = err < {10'd0, best_err_r};
  assign step_lez   = (state_r == S_RATE) ? err_zero : lez_r;
  assign adv_finish = (add_r == MaxFr) && (step_lez || (mul_r == MaxFr));
  assign scale_num  = {23'd0, mul_r} * {4'd0, uclk_r};
  assign scale_den  = {1'b0, mul_r} + {1'b0, add_r};
  assign baud_x3    = {4'd0, baud_r} + {3'd0, baud_r, 1'b0};

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      main_clk_r  <= MainClkRst;
      uart_div_r  <= UartDivRst;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CfgMainClk) main_clk_r <= cfg_data;
        if (cfg_index == CfgUartDiv) uart_div_r <= cfg_data[7:0];
      end
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            baud_r     <= in_baud_rate;
            mul_r      <= 4'd1;
            add_r      <= 4'd0;
            lez_r      <= 1'b1;
            best_div_r <= 16'd0;
            best_mul_r <= 4'd1;
            best_add_r <= 4'd0;
            best_err_r <= NoErr;
            div_go_r   <= 1'b1;
            div_num_r  <= main_clk_r;
            div_den_r  <= {15'd0, clkdiv_eff};
            state_r    <= S_UCLK;
          end
        end
        S_UCLK: begin
          if (rsp.done) begin
            uclk_r <= rsp.quo[DW-1:4];
            if (baud_r == 23'd0) begin
              // no pair can be valid: straight to the threshold
              div_go_r  <= 1'b1;
              div_num_r <= baud_x3;
              div_den_r <= {16'd0, PctScale};
              state_r   <= S_ACC;
            end else begin
              state_r <= S_PAIR;
            end
          end
        end
        S_PAIR: begin
          div_go_r  <= 1'b1;
          div_num_r <= scale_num;
          div_den_r <= {18'd0, scale_den};
          state_r   <= S_SCALE;
        end
        S_SCALE: begin
          if (rsp.done) begin
            scaled_r  <= rsp.quo;
            div_go_r  <= 1'b1;
            div_num_r <= rsp.quo;
            div_den_r <= baud_r;
            state_r   <= S_QUOT;
          end
        end
        S_QUOT, S_RATE: begin
          if (rsp.done) begin
            if (state_r == S_QUOT && dq_ok) begin
              cand_div_r <= dq[15:0];
              div_go_r   <= 1'b1;
              div_num_r  <= scaled_r;
              div_den_r  <= {7'd0, dq[15:0]};
              state_r    <= S_RATE;
            end else begin
              if (state_r == S_RATE) begin
                lez_r <= err_zero;
                if (better) begin
                  best_div_r <= cand_div_r;
                  best_mul_r <= mul_r;
                  best_add_r <= add_r;
                  best_err_r <= err[16:0];
                end
              end
              if (adv_finish || (state_r == S_RATE && err_zero)) begin
                div_go_r  <= 1'b1;
                div_num_r <= baud_x3;
                div_den_r <= {16'd0, PctScale};
                state_r   <= S_ACC;
              end else begin
                if (add_r == MaxFr) begin
                  mul_r <= mul_r + 4'd1;
                  add_r <= 4'd0;
                end else begin
                  add_r <= add_r + 4'd1;
                end
                state_r <= S_PAIR;
              end
            end
          end
        end
        S_ACC: begin
          if (rsp.done) begin
            thresh_r <= rsp.quo;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_div_r   <= best_div_r;
            out_mul_r   <= best_mul_r;
            out_add_r   <= best_add_r;
            out_err_r   <= best_err_r;
            out_acc_r   <= ({10'd0, best_err_r} < thresh_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_divisor     = out_div_r;
  assign out_mul_val     = out_mul_r;
  assign out_div_add_val = out_add_r;
  assign out_best_error  = out_err_r;
  assign out_accepted    = out_acc_r;

  // a divider result only lands in a state that waits for it
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_UCLK || state_r == S_SCALE || state_r == S_QUOT ||
                  state_r == S_RATE || state_r == S_ACC))
    else $error("divider result with no waiting state");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> !rsp.busy)
    else $error("divider started while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside output state");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_UCLK) |-> (best_err_r <= NoErr))
    else $error("best error above initial value");

endmodule

`default_nettype wire
